// File: design/max_pooling_forward_backward_defines.svh
// assertion macros shared by the max pooling block
`ifndef MAX_POOLING_FORWARD_BACKWARD_DEFINES_SVH
`define MAX_POOLING_FORWARD_BACKWARD_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define MPFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mpfb_pkg.sv
// package: types, constants and helpers of the max pooling block
`timescale 1ns / 1ps

package mpfb_pkg;

  localparam int MAX_IN_COLS_DEF = 256;
  localparam int DATA_WIDTH_DEF  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_IN_ROWS       = 3'd1,
    REG_IN_COLS       = 3'd2,
    REG_POOL_ROWS     = 3'd3,
    REG_POOL_COLS     = 3'd4
  } cfg_reg_t;

  localparam logic FUNC_FORWARD  = 1'b0;
  localparam logic FUNC_BACKWARD = 1'b1;

  localparam logic [8:0] CHANS_MAX   = 9'd64;
  localparam logic [8:0] ROWS_MAX    = 9'd256;
  localparam logic [8:0] POOL_MAX    = 9'd16;
  localparam logic [8:0] CHANS_RESET = 9'd1;
  localparam logic [8:0] ROWS_RESET  = 9'd8;
  localparam logic [8:0] COLS_RESET  = 9'd8;
  localparam logic [8:0] POOL_RESET  = 9'd2;

  // control flags carried from the sequencer into the update stage
  typedef struct packed {
    logic is_grad;
    logic upd;
    logic first_row;
    logic last_row;
  } s1_ctrl_t;

  // zero counts as one, anything above hi saturates
  function automatic logic [8:0] clamp_count(input logic [8:0] v, input logic [8:0] hi);
    logic [8:0] r;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: design/mpfb_line_store.sv
// line store: per pooled column partial maximum, one write and one registered read port
`timescale 1ns / 1ps

module mpfb_line_store #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 16,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                wr_addr,
  input  logic signed [DATA_WIDTH-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic signed [DATA_WIDTH-1:0] rd_data
);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/mpfb_seq.sv
// sequencer: configuration registers, raster position counters, row running max, stage 1 register
`timescale 1ns / 1ps

module mpfb_seq #(
  parameter int MAX_IN_COLS = mpfb_pkg::MAX_IN_COLS_DEF,
  parameter int DATA_WIDTH  = mpfb_pkg::DATA_WIDTH_DEF,
  localparam int DEPTH      = (MAX_IN_COLS < 256) ? MAX_IN_COLS : 256,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [mpfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpfb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_accept,
  input  logic                              in_func,
  input  logic signed [DATA_WIDTH-1:0]      in_sample,
  input  logic signed [DATA_WIDTH-1:0]      in_wmax,
  input  logic signed [DATA_WIDTH-1:0]      in_grad,
  input  logic                              s1_fire,
  output logic                              s1_valid,
  output mpfb_pkg::s1_ctrl_t                s1_ctrl,
  output logic [AW-1:0]                     s1_addr,
  output logic [5:0]                        s1_chan,
  output logic [7:0]                        s1_row,
  output logic [7:0]                        s1_col,
  output logic signed [DATA_WIDTH-1:0]      s1_value,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr
);

  localparam logic [8:0] COLS_CAP = 9'(DEPTH);

  // clamped configuration
  logic [6:0] chans_r, chans_nxt;
  logic [8:0] rows_r, rows_nxt;
  logic [8:0] cols_r, cols_nxt;
  logic [4:0] pr_r, pr_nxt;
  logic [4:0] pc_r, pc_nxt;
  logic       cfg_hit;

  // raster position
  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;
  logic [5:0] chan_r, chan_nxt;
  logic [3:0] iwc_r, iwc_nxt;
  logic [7:0] wc_r, wc_nxt;
  logic [3:0] iwr_r, iwr_nxt;
  logic [7:0] wr_r, wr_nxt;

  logic signed [DATA_WIDTH-1:0] rrm_r, rrm_nxt;

  logic                         s1_valid_r, s1_valid_nxt;
  mpfb_pkg::s1_ctrl_t           s1_ctrl_r;
  logic [AW-1:0]                s1_addr_r;
  logic [5:0]                   s1_chan_r;
  logic [7:0]                   s1_row_r;
  logic [7:0]                   s1_col_r;
  logic signed [DATA_WIDTH-1:0] s1_value_r;

  logic       fwd_acc;
  logic       col_full, row_full, in_region;
  logic       iwc_last, iwr_last, col_last, row_last, chan_last;
  logic       take_x;
  logic signed [DATA_WIDTH-1:0] fwd_max, bwd_val;

  // configuration decode
  always_comb begin
    chans_nxt = chans_r;
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    pr_nxt    = pr_r;
    pc_nxt    = pc_r;
    cfg_hit   = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        mpfb_pkg::REG_CHANNEL_COUNT: begin
          chans_nxt = 7'(mpfb_pkg::clamp_count({2'b0, cfg_data[6:0]}, mpfb_pkg::CHANS_MAX));
          cfg_hit   = 1'b1;
        end
        mpfb_pkg::REG_IN_ROWS: begin
          rows_nxt = mpfb_pkg::clamp_count(cfg_data, mpfb_pkg::ROWS_MAX);
          cfg_hit  = 1'b1;
        end
        mpfb_pkg::REG_IN_COLS: begin
          cols_nxt = mpfb_pkg::clamp_count(cfg_data, COLS_CAP);
          cfg_hit  = 1'b1;
        end
        mpfb_pkg::REG_POOL_ROWS: begin
          pr_nxt  = 5'(mpfb_pkg::clamp_count({4'b0, cfg_data[4:0]}, mpfb_pkg::POOL_MAX));
          cfg_hit = 1'b1;
        end
        mpfb_pkg::REG_POOL_COLS: begin
          pc_nxt  = 5'(mpfb_pkg::clamp_count({4'b0, cfg_data[4:0]}, mpfb_pkg::POOL_MAX));
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // window bookkeeping for the current element
  always_comb begin
    fwd_acc   = in_accept && (in_func == mpfb_pkg::FUNC_FORWARD);
    // a window counts only if it ends inside the map
    col_full  = (({2'b0, col_r} - {6'b0, iwc_r} + {5'b0, pc_r}) <= {1'b0, cols_r});
    row_full  = (({2'b0, row_r} - {6'b0, iwr_r} + {5'b0, pr_r}) <= {1'b0, rows_r});
    in_region = col_full && row_full;
    iwc_last  = ({1'b0, iwc_r} == (pc_r - 5'd1));
    iwr_last  = ({1'b0, iwr_r} == (pr_r - 5'd1));
    col_last  = (({1'b0, col_r} + 9'd1) >= cols_r);
    row_last  = (({1'b0, row_r} + 9'd1) >= rows_r);
    chan_last = (({1'b0, chan_r} + 7'd1) >= chans_r);
    take_x    = (iwc_r == 4'd0) || (in_sample > rrm_r);
    fwd_max   = take_x ? in_sample : rrm_r;
    bwd_val   = (in_sample == in_wmax) ? in_grad : '0;
  end

  // position and running max update
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    chan_nxt = chan_r;
    iwc_nxt  = iwc_r;
    wc_nxt   = wc_r;
    iwr_nxt  = iwr_r;
    wr_nxt   = wr_r;
    rrm_nxt  = rrm_r;
    if (cfg_hit) begin
      col_nxt  = '0;
      row_nxt  = '0;
      chan_nxt = '0;
      iwc_nxt  = '0;
      wc_nxt   = '0;
      iwr_nxt  = '0;
      wr_nxt   = '0;
    end else if (fwd_acc) begin
      if (in_region) begin
        rrm_nxt = fwd_max;
      end
      if (col_last) begin
        col_nxt = '0;
        iwc_nxt = '0;
        wc_nxt  = '0;
        if (row_last) begin
          row_nxt  = '0;
          iwr_nxt  = '0;
          wr_nxt   = '0;
          chan_nxt = chan_last ? 6'd0 : chan_r + 6'd1;
        end else begin
          row_nxt = row_r + 8'd1;
          if (iwr_last) begin
            iwr_nxt = '0;
            wr_nxt  = wr_r + 8'd1;
          end else begin
            iwr_nxt = iwr_r + 4'd1;
          end
        end
      end else begin
        col_nxt = col_r + 8'd1;
        if (iwc_last) begin
          iwc_nxt = '0;
          wc_nxt  = wc_r + 8'd1;
        end else begin
          iwc_nxt = iwc_r + 4'd1;
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_r    <= 7'(mpfb_pkg::CHANS_RESET);
      rows_r     <= mpfb_pkg::ROWS_RESET;
      cols_r     <= mpfb_pkg::clamp_count(mpfb_pkg::COLS_RESET, COLS_CAP);
      pr_r       <= 5'(mpfb_pkg::POOL_RESET);
      pc_r       <= 5'(mpfb_pkg::POOL_RESET);
      col_r      <= '0;
      row_r      <= '0;
      chan_r     <= '0;
      iwc_r      <= '0;
      wc_r       <= '0;
      iwr_r      <= '0;
      wr_r       <= '0;
      rrm_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      chans_r    <= chans_nxt;
      rows_r     <= rows_nxt;
      cols_r     <= cols_nxt;
      pr_r       <= pr_nxt;
      pc_r       <= pc_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      chan_r     <= chan_nxt;
      iwc_r      <= iwc_nxt;
      wc_r       <= wc_nxt;
      iwr_r      <= iwr_nxt;
      wr_r       <= wr_nxt;
      rrm_r      <= rrm_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (in_func == mpfb_pkg::FUNC_BACKWARD) begin
        s1_ctrl_r  <= '{is_grad: 1'b1, upd: 1'b0, first_row: 1'b0, last_row: 1'b0};
        s1_chan_r  <= '0;
        s1_row_r   <= '0;
        s1_col_r   <= '0;
        s1_value_r <= bwd_val;
      end else begin
        s1_ctrl_r  <= '{is_grad: 1'b0, upd: in_region && iwc_last,
                        first_row: (iwr_r == 4'd0), last_row: iwr_last};
        s1_chan_r  <= chan_r;
        s1_row_r   <= wr_r;
        s1_col_r   <= wc_r;
        s1_value_r <= fwd_max;
      end
      s1_addr_r <= wc_r[AW-1:0];
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_ctrl  = s1_ctrl_r;
  assign s1_addr  = s1_addr_r;
  assign s1_chan  = s1_chan_r;
  assign s1_row   = s1_row_r;
  assign s1_col   = s1_col_r;
  assign s1_value = s1_value_r;
  assign rd_en    = in_accept;
  assign rd_addr  = wc_r[AW-1:0];

endmodule

// File: design/mpfb_update.sv
// update stage: merge with the line store, write back with forwarding, output register
`timescale 1ns / 1ps
`include "max_pooling_forward_backward_defines.svh"

module mpfb_update #(
  parameter int MAX_IN_COLS = mpfb_pkg::MAX_IN_COLS_DEF,
  parameter int DATA_WIDTH  = mpfb_pkg::DATA_WIDTH_DEF,
  localparam int DEPTH      = (MAX_IN_COLS < 256) ? MAX_IN_COLS : 256,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  mpfb_pkg::s1_ctrl_t            s1_ctrl,
  input  logic [AW-1:0]                 s1_addr,
  input  logic [5:0]                    s1_chan,
  input  logic [7:0]                    s1_row,
  input  logic [7:0]                    s1_col,
  input  logic signed [DATA_WIDTH-1:0]  s1_value,
  input  logic signed [DATA_WIDTH-1:0]  rd_data,
  output logic                          s1_fire,
  output logic                          s1_ready,
  output logic                          we,
  output logic [AW-1:0]                 wr_addr,
  output logic signed [DATA_WIDTH-1:0]  wr_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  out_value,
  output logic                          out_is_grad,
  output logic [5:0]                    out_chan,
  output logic [7:0]                    out_row,
  output logic [7:0]                    out_col
);

  logic                         emit;
  logic                         fwd_hit;
  logic signed [DATA_WIDTH-1:0] stored, merged;

  // last write to the line store, covers a read issued in the same cycle
  logic                         fwd_valid_r, fwd_valid_nxt;
  logic [AW-1:0]                fwd_addr_r;
  logic signed [DATA_WIDTH-1:0] fwd_data_r;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_value_r;
  logic                         out_grad_r;
  logic [5:0]                   out_chan_r;
  logic [7:0]                   out_row_r;
  logic [7:0]                   out_col_r;

  always_comb begin
    emit     = s1_ctrl.is_grad || (s1_ctrl.upd && s1_ctrl.last_row);
    s1_fire  = s1_valid && (!emit || !out_valid_r || out_ready);
    s1_ready = !s1_valid || s1_fire;
    fwd_hit  = fwd_valid_r && (fwd_addr_r == s1_addr);
    stored   = fwd_hit ? fwd_data_r : rd_data;
    merged   = (s1_ctrl.first_row || (s1_value > stored)) ? s1_value : stored;
    we       = s1_fire && s1_ctrl.upd;
    wr_addr  = s1_addr;
    wr_data  = merged;
  end

  always_comb begin
    fwd_valid_nxt = fwd_valid_r || we;
    out_valid_nxt = out_valid_r;
    if (s1_fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
    if (s1_fire && emit) begin
      out_value_r <= s1_ctrl.is_grad ? s1_value : merged;
      out_grad_r  <= s1_ctrl.is_grad;
      out_chan_r  <= s1_chan;
      out_row_r   <= s1_row;
      out_col_r   <= s1_col;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_is_grad = out_grad_r;
  assign out_chan    = out_chan_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;

  `MPFB_ASSERT_NOW(a_grad_no_position, out_valid_r && out_grad_r, (out_chan_r == 6'd0) && (out_row_r == 8'd0) && (out_col_r == 8'd0), "gradient result carries a position")
  `MPFB_ASSERT_NEXT(a_stage_holds, s1_valid && !s1_fire, s1_valid, "stalled stage 1 transaction dropped")
  `MPFB_ASSERT_NEXT(a_emit_lands, s1_fire && emit, out_valid_r, "emitted result not in output register")
  `MPFB_ASSERT_NEXT(a_write_recorded, we, fwd_valid_r && (fwd_addr_r == $past(wr_addr)), "line store write not tracked for forwarding")

endmodule

// File: design/max_pooling_forward_backward.sv
// top level: streaming max pooling, forward windows and backward gradient routing
//
//  channel | direction | tdata / data                         | tuser
//  in_     | slave     | sample_value, window_max, upstream_grad | func
//  out_    | master    | out_value, channel_index, out_row, out_col | is_gradient
//  cfg_    | slave     | cfg_index (register), cfg_data        | -
//
// one transaction per cycle sustained while out_ does not stall; a result passes the stage 1 and output registers
// the line store is read when an element is accepted and written back when stage 1 fires,
// a forwarding register covers back-to-back updates of the same pooled column
// rst_n clears positions, running max and configuration (1, 8, 8, 2, 2); the store needs no clear
// a stalled out_ stalls in_ only when the waiting element itself has a result to give
`timescale 1ns / 1ps

module max_pooling_forward_backward #(
  parameter int MAX_IN_COLS   = mpfb_pkg::MAX_IN_COLS_DEF,
  parameter int DATA_WIDTH    = mpfb_pkg::DATA_WIDTH_DEF,
  localparam int IN_TDATA_W   = ((3 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W  = ((DATA_WIDTH + 22 + 7) / 8) * 8,
  localparam int DEPTH        = (MAX_IN_COLS < 256) ? MAX_IN_COLS : 256,
  localparam int AW           = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpfb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sample_value, window_max, upstream_grad, zero pad
  input  logic [IN_TDATA_W-1:0]           in_tdata,
  // func
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_value, channel_index, out_row, out_col, zero pad
  output logic [OUT_TDATA_W-1:0]          out_tdata,
  // is_gradient
  output logic                            out_tuser
);

  logic                         in_accept;
  logic                         s1_fire, s1_ready, s1_valid;
  mpfb_pkg::s1_ctrl_t           s1_ctrl;
  logic [AW-1:0]                s1_addr;
  logic [5:0]                   s1_chan;
  logic [7:0]                   s1_row, s1_col;
  logic signed [DATA_WIDTH-1:0] s1_value;
  logic                         rd_en, we;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic signed [DATA_WIDTH-1:0] rd_data, wr_data;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic [5:0]                   out_chan;
  logic [7:0]                   out_row, out_col;

  assign cfg_ready = 1'b1;
  assign in_tready = s1_ready;
  assign in_accept = in_tvalid && s1_ready;

  mpfb_seq #(
    .MAX_IN_COLS (MAX_IN_COLS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_func   (in_tuser),
    .in_sample (in_tdata[DATA_WIDTH-1:0]),
    .in_wmax   (in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .in_grad   (in_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
    .s1_fire   (s1_fire),
    .s1_valid  (s1_valid),
    .s1_ctrl   (s1_ctrl),
    .s1_addr   (s1_addr),
    .s1_chan   (s1_chan),
    .s1_row    (s1_row),
    .s1_col    (s1_col),
    .s1_value  (s1_value),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  mpfb_line_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mpfb_update #(
    .MAX_IN_COLS (MAX_IN_COLS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_update (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_ctrl     (s1_ctrl),
    .s1_addr     (s1_addr),
    .s1_chan     (s1_chan),
    .s1_row      (s1_row),
    .s1_col      (s1_col),
    .s1_value    (s1_value),
    .rd_data     (rd_data),
    .s1_fire     (s1_fire),
    .s1_ready    (s1_ready),
    .we          (we),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_value   (out_value),
    .out_is_grad (out_tuser),
    .out_chan    (out_chan),
    .out_row     (out_row),
    .out_col     (out_col)
  );

  assign out_tdata = OUT_TDATA_W'({out_col, out_row, out_chan, out_value});

endmodule

// File: sim/tb.sv
// testbench for max_pooling_forward_backward: directed table plus random phases, self-checking
`timescale 1ns / 1ps

module tb;
  import mpfb_pkg::*;

  localparam int IN_TDATA_W  = ((3 * DATA_WIDTH_DEF + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH_DEF + 22 + 7) / 8) * 8;
  localparam int STORE_DEPTH = MAX_IN_COLS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_PRINTS    = 40;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct packed {
    logic               func;
    logic signed [15:0] sample;
    logic signed [15:0] wmax;
    logic signed [15:0] grad;
  } pool_item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               is_grad;
    logic [5:0]         chan;
    logic [7:0]         row;
    logic [7:0]         col;
  } pool_result_t;

  // typed: expectation written in the table instead of taken from the predictor
  typedef struct packed {
    pool_item_t   item;
    logic         typed;
    logic         has_res;
    pool_result_t res;
  } stim_row_t;

  typedef struct packed {
    int chans;
    int rows;
    int cols;
    int prow;
    int pcol;
    int n_items;
    int mode;
    bit junk_only;
    bit long_hold;
    bit mid_drain;
  } phase_t;

  // reset config: 1 channel, 8x8 map, 2x2 windows
  localparam stim_row_t DIRECTED [21] = '{
    '{'{FUNC_BACKWARD, 16'h8000, 16'h8000, 16'h7FFF}, 1'b1, 1'b1, '{16'h7FFF, 1'b1, 6'd0, 8'd0, 8'd0}},
    '{'{FUNC_BACKWARD, 16'h7FFF, 16'h7FFF, 16'h8000}, 1'b1, 1'b1, '{16'h8000, 1'b1, 6'd0, 8'd0, 8'd0}},
    '{'{FUNC_BACKWARD, 16'h7FFF, 16'h8000, 16'h1234}, 1'b1, 1'b1, '{16'h0000, 1'b1, 6'd0, 8'd0, 8'd0}},
    '{'{FUNC_BACKWARD, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h8000, 16'h5A5A, 16'hA5A5}, 1'b1, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h8000, 16'hA5A5, 16'h5A5A}, 1'b1, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h7FFF, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    // backward in the middle of a row must leave the window state alone
    '{'{FUNC_BACKWARD, 16'h0100, 16'h0101, 16'h7FFF}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'hFFFF, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h0000, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h0100, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h0000, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'hFFFF, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h8000, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h8000, 16'h5A5A, 16'hA5A5}, 1'b1, 1'b1, '{16'h8000, 1'b0, 6'd0, 8'd0, 8'd0}},
    '{'{FUNC_FORWARD,  16'h0005, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h8000, 16'h5A5A, 16'hA5A5}, 1'b1, 1'b1, '{16'h7FFF, 1'b0, 6'd0, 8'd0, 8'd1}},
    '{'{FUNC_FORWARD,  16'h0100, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h0100, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'hFFFE, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0},
    '{'{FUNC_FORWARD,  16'h8000, 16'h5A5A, 16'hA5A5}, 1'b0, 1'b0, '0}
  };

  // chans, rows, cols, pool rows, pool cols, items, idling, junk writes, long hold, mid drain
  localparam phase_t PHASES [12] = '{
    '{1, 8, 8, 2, 2, 150, IDLE_NONE, 1'b1, 1'b0, 1'b0},
    '{3, 6, 7, 3, 2, 150, IDLE_SEND, 1'b0, 1'b0, 1'b0},
    '{511, 1, 1, 1, 1, 150, IDLE_RECV, 1'b0, 1'b0, 1'b0},
    '{0, 0, 0, 0, 0, 60, IDLE_BOTH, 1'b0, 1'b0, 1'b0},
    '{1, 256, 1, 1, 1, 260, IDLE_NONE, 1'b0, 1'b0, 1'b0},
    '{2, 4, 511, 1, 1, 260, IDLE_SEND, 1'b0, 1'b0, 1'b0},
    '{1, 33, 3, 31, 1, 150, IDLE_RECV, 1'b0, 1'b0, 1'b0},
    '{1, 2, 17, 1, 16, 100, IDLE_BOTH, 1'b0, 1'b0, 1'b0},
    '{2, 3, 5, 4, 6, 60, IDLE_NONE, 1'b0, 1'b0, 1'b0},
    '{1, 1, 1, 1, 1, 300, IDLE_NONE, 1'b0, 1'b1, 1'b0},
    '{5, 9, 10, 2, 3, 250, IDLE_BOTH, 1'b0, 1'b0, 1'b1},
    '{1, 8, 8, 2, 2, 60, IDLE_RECV, 1'b0, 1'b0, 1'b0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // sideband that travels with the item on offer
  logic                   drv_typed;
  logic                   drv_has_res;
  pool_result_t           drv_res;
  logic                   hold_start;

  int send_idle_pct;
  int rx_stall_pct;
  int err_count;

  // predictor state
  logic [6:0]         chan_reg;
  logic [8:0]         rows_reg;
  logic [8:0]         cols_reg;
  logic [4:0]         prow_reg;
  logic [4:0]         pcol_reg;
  int                 col_pos;
  int                 row_pos;
  int                 chan_pos;
  logic signed [15:0] run_max;
  logic signed [15:0] col_max_mem [STORE_DEPTH];

  pool_result_t pool_expect_q [$];

  max_pooling_forward_backward u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (err_count < MAX_PRINTS) begin
      $display("%0d ns: mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
    end
    err_count++;
  endtask

  function automatic int fit_count(input int v, input int hi);
    if (v == 0) begin
      return 1;
    end
    return (v > hi) ? hi : v;
  endfunction

  // one accepted item in, zero or one pooled result out
  function automatic bit pool_predict(input pool_item_t it, output pool_result_t res);
    int chans, rows, cols, pr, pc, wcol, wc_in, wr_in;
    bit hit;
    hit = 1'b0;
    res = '0;
    if (it.func == FUNC_BACKWARD) begin
      res.value = (it.sample == it.wmax) ? it.grad : 16'sd0;
      res.is_grad = 1'b1;
      return 1'b1;
    end
    chans = fit_count(chan_reg, 64);
    rows = fit_count(rows_reg, 256);
    cols = fit_count(cols_reg, STORE_DEPTH);
    pr = fit_count(prow_reg, 16);
    pc = fit_count(pcol_reg, 16);
    // trailing rows and columns outside whole windows are skipped
    if (row_pos < (rows / pr) * pr && col_pos < (cols / pc) * pc) begin
      wcol = col_pos / pc;
      wc_in = col_pos % pc;
      wr_in = row_pos % pr;
      if (wc_in == 0 || it.sample > run_max) begin
        run_max = it.sample;
      end
      if (wc_in == pc - 1) begin
        if (wr_in == 0 || run_max > col_max_mem[wcol]) begin
          col_max_mem[wcol] = run_max;
        end
        if (wr_in == pr - 1) begin
          res.value = col_max_mem[wcol];
          res.chan = 6'(chan_pos);
          res.row = 8'(row_pos / pr);
          res.col = 8'(wcol);
          hit = 1'b1;
        end
      end
    end
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) begin
        row_pos = 0;
        chan_pos++;
        if (chan_pos >= chans) begin
          chan_pos = 0;
        end
      end
    end
    return hit;
  endfunction

  // results are checked before new predictions go in, all at the clock edge
  always @(posedge clk) begin : scoreboard
    pool_result_t got;
    pool_result_t want;
    pool_item_t   item;
    if (!rst_n) begin
      chan_reg = 7'(CHANS_RESET);
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      prow_reg = 5'(POOL_RESET);
      pcol_reg = 5'(POOL_RESET);
      col_pos = 0;
      row_pos = 0;
      chan_pos = 0;
      run_max = '0;
      foreach (col_max_mem[i]) col_max_mem[i] = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[15:0];
        got.chan = out_tdata[21:16];
        got.row = out_tdata[29:22];
        got.col = out_tdata[37:30];
        got.is_grad = out_tuser;
        if (out_tdata[OUT_TDATA_W-1:38] !== '0) begin
          report_mismatch("tdata padding", int'(out_tdata[OUT_TDATA_W-1:38]), 0);
        end
        if (pool_expect_q.size() == 0) begin
          report_mismatch("result with nothing pending, value", got.value, 0);
        end else begin
          want = pool_expect_q.pop_front();
          if (got.value !== want.value) report_mismatch("out_value", got.value, want.value);
          if (got.is_grad !== want.is_grad) report_mismatch("is_gradient", got.is_grad, want.is_grad);
          if (got.chan !== want.chan) report_mismatch("channel_index", got.chan, want.chan);
          if (got.row !== want.row) report_mismatch("out_row", got.row, want.row);
          if (got.col !== want.col) report_mismatch("out_col", got.col, want.col);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: chan_reg = cfg_data[6:0];
          REG_IN_ROWS:       rows_reg = cfg_data;
          REG_IN_COLS:       cols_reg = cfg_data;
          REG_POOL_ROWS:     prow_reg = cfg_data[4:0];
          REG_POOL_COLS:     pcol_reg = cfg_data[4:0];
          default: ;
        endcase
        // any listed register restarts the frame
        if (cfg_index <= REG_POOL_COLS) begin
          col_pos = 0;
          row_pos = 0;
          chan_pos = 0;
        end
      end
      if (in_tvalid && in_tready) begin
        item.func = in_tuser;
        item.sample = in_tdata[15:0];
        item.wmax = in_tdata[31:16];
        item.grad = in_tdata[47:32];
        if (pool_predict(item, want) && !drv_typed) begin
          pool_expect_q.push_back(want);
        end
        if (drv_typed && drv_has_res) begin
          pool_expect_q.push_back(drv_res);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_item(input pool_item_t it, input logic typed, input logic has_res,
                           input pool_result_t res);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.func;
    in_tdata <= {it.grad, it.wmax, it.sample};
    drv_typed <= typed;
    drv_has_res <= has_res;
    drv_res <= res;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop offering, wait for every pending result, then let the pipeline settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pool_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    phase_t     ph;
    pool_item_t it;
    err_count = 0;
    send_idle_pct = 0;
    rx_stall_pct = 0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= FUNC_FORWARD;
    drv_typed <= 1'b0;
    drv_has_res <= 1'b0;
    drv_res <= '0;
    hold_start <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].has_res, DIRECTED[i].res);
    end
    wait_drained();

    foreach (PHASES[p]) begin
      ph = PHASES[p];
      if (ph.junk_only) begin
        // unlisted indexes: registers and frame position stay as they are
        for (int j = int'(REG_POOL_COLS) + 1; j < (1 << CFG_IDX_W); j++) begin
          write_reg(CFG_IDX_W'(j), $urandom);
        end
      end else begin
        write_reg(REG_CHANNEL_COUNT, ph.chans);
        write_reg(REG_IN_ROWS, ph.rows);
        write_reg(REG_IN_COLS, ph.cols);
        write_reg(REG_POOL_ROWS, ph.prow);
        write_reg(REG_POOL_COLS, ph.pcol);
      end
      cfg_valid <= 1'b0;
      case (ph.mode)
        IDLE_SEND: begin send_idle_pct = 77; rx_stall_pct = 0; end
        IDLE_RECV: begin send_idle_pct = 0; rx_stall_pct = 77; end
        IDLE_BOTH: begin send_idle_pct = 25; rx_stall_pct = 25; end
        default:   begin send_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      @(posedge clk);
      if (ph.long_hold) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      for (int n = 0; n < ph.n_items; n++) begin
        if (ph.mid_drain && n == ph.n_items / 2) begin
          wait_drained();
        end
        it.func = ($urandom_range(99) < 80) ? FUNC_FORWARD : FUNC_BACKWARD;
        // small values now and then so ties and equal maxima show up
        it.sample = ($urandom_range(3) == 0) ? 16'($urandom_range(8) - 4) : 16'($urandom);
        it.wmax = $urandom_range(1) ? it.sample : 16'($urandom);
        it.grad = 16'($urandom);
        send_item(it, 1'b0, 1'b0, '0);
      end
      wait_drained();
    end

    in_tvalid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && pool_expect_q.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pool_expect_q.size() != 0) begin
      report_mismatch("results still pending", pool_expect_q.size(), 0);
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
